// ===== src/scr_charger_firing_regulator_unit_assert.svh =====
// Assertion macros shared by the firing regulator RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SCR_CHARGER_FIRING_REGULATOR_UNIT_ASSERT_SVH
`define SCR_CHARGER_FIRING_REGULATOR_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SCFR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("scfr: invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define SCFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scfr: implication violated");

// A consequence that must hold in the cycle after its cause.
`define SCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scfr: next-cycle check violated");

`endif

// ===== src/scfr_pkg.sv =====
// Shared constants, configuration codes and stage structs of the firing regulator.
// No dependencies; every RTL module of the block imports it.
package scfr_pkg;

    localparam int WINDOW_SAMPLES = 40;
    localparam int IDX_W          = $clog2(WINDOW_SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SAMPLES - 1);

    localparam int SMP_W  = 10;
    localparam int SUM_W  = 16;
    localparam int TMR_W  = 16;
    localparam int VT_W   = 9;
    localparam int CT_W   = 15;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    localparam logic [SMP_W-1:0] MIN_RESET   = 10'd1023;
    localparam logic [TMR_W-1:0] TIMER_MIN   = 16'd59694;
    localparam logic [TMR_W-1:0] TIMER_MAX   = 16'd63973;
    localparam logic [TMR_W-1:0] TIMER_RESET = 16'd60067;

    // Voltage compare domain: everything scaled by 51200 * WINDOW_SAMPLES.
    localparam int VL_W     = 28;
    localparam int SPS_W    = 34;
    localparam int V_SCALE  = 2500;
    localparam int SP_SCALE = 5120 * WINDOW_SAMPLES;
    localparam int LO_OFS   = 512 * WINDOW_SAMPLES;
    localparam int HI_OFS   = 1536 * WINDOW_SAMPLES;
    localparam int V_UNIT   = 51200 * WINDOW_SAMPLES;

    // Current limit domain (scaled by 384000) and difference domain (by 3840).
    localparam int IL_W       = 30;
    localparam int CUR_W      = 32;
    localparam int IM_W       = 23;
    localparam int CSS_W      = 25;
    localparam int IDIF_W     = 26;
    localparam int I_SCALE    = 625000;
    localparam int I_BELOW    = 38016;
    localparam int I_ABOVE    = 38784;
    localparam int IM_SCALE   = 6250;
    localparam int IS_SCALE   = 384;
    localparam int I_DIFF_LIM = 38400;

    // Display scaling. sum*125/(256*40) reduces to sum*25/2048.
    // min*6250/384 = ((min*3125) >> 6) / 3, and the divide by three is a
    // multiply by ceil(2^17/3) followed by a 17 bit shift, exact below 2^16.
    localparam int DISP_V_MUL    = 25;
    localparam int DISP_V_SHIFT  = 11;
    localparam int DISP_I_MUL    = 3125;
    localparam int DISP_I_SHIFT  = 6;
    localparam int IDIV_W        = 16;
    localparam int RECIP3        = 43691;
    localparam int RECIP3_SHIFT  = 17;

    typedef enum logic [CIDX_W-1:0] {
        CFG_VOLTAGE_SETPOINT = 2'd0,
        CFG_CURRENT_SETPOINT = 2'd1,
        CFG_REGULATE_ENABLE  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SMP_W-1:0] mn;
    } t_window;

    typedef struct packed {
        logic [VL_W-1:0]   vl;
        logic [IL_W-1:0]   il;
        logic [IM_W-1:0]   im;
        logic [IDIV_W-1:0] idiv;
        logic [VT_W-1:0]   vdisp;
    } t_scaled;

endpackage

// ===== src/scfr_accum.sv =====
// Window accumulator: sums voltage samples and tracks the current minimum.
// Depends on scfr_pkg; hands each finished window on through a register stage.
`include "scr_charger_firing_regulator_unit_assert.svh"

module scfr_accum import scfr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SMP_W-1:0] i_voltage_sample,
    input  logic [SMP_W-1:0] i_current_sample,
    output logic             o_win_valid,
    output t_window          o_win,
    input  logic             i_win_ready
);

    logic [SUM_W-1:0] r_sum;
    logic [SMP_W-1:0] r_min;
    logic [IDX_W-1:0] r_idx;
    logic             r_w_valid;
    t_window          r_win;

    logic [SUM_W-1:0] n_sum;
    logic [SMP_W-1:0] n_min;
    logic             w_last;
    logic             w_accept;

    assign w_last   = (r_idx == IDX_LAST);
    // Only the closing sample of a window needs room in the window stage.
    assign o_ready  = !w_last || !r_w_valid || i_win_ready;
    assign w_accept = i_valid && o_ready;
    assign n_sum    = r_sum + SUM_W'(i_voltage_sample);
    assign n_min    = (i_current_sample < r_min) ? i_current_sample : r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_min     <= MIN_RESET;
            r_idx     <= '0;
            r_w_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_last) begin
                    r_sum <= '0;
                    r_min <= MIN_RESET;
                    r_idx <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_min <= n_min;
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_accept && w_last) begin
                r_w_valid <= 1'b1;
            end else if (i_win_ready) begin
                r_w_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_win.sum <= n_sum;
            r_win.mn  <= n_min;
        end
    end

    assign o_win_valid = r_w_valid;
    assign o_win       = r_win;

    `SCFR_ASSERT_ALWAYS(a_idx_range, r_idx <= IDX_LAST)

endmodule

// ===== src/scfr_scale.sv =====
// Scaling stage: turns a window's sum and minimum into the products used
// for regulation and display. Depends on scfr_pkg.
module scfr_scale import scfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_win_valid,
    input  t_window i_win,
    output logic    o_win_ready,
    output logic    o_scl_valid,
    output t_scaled o_scl,
    input  logic    i_scl_ready
);

    logic    r_valid;
    t_scaled r_scl;
    logic    w_take;

    assign o_win_ready = !r_valid || i_scl_ready;
    assign w_take      = i_win_valid && o_win_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_scl_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_scl.vl    <= VL_W'(32'(i_win.sum) * 32'(V_SCALE));
            r_scl.il    <= IL_W'(32'(i_win.mn) * 32'(I_SCALE));
            r_scl.im    <= IM_W'(32'(i_win.mn) * 32'(IM_SCALE));
            r_scl.idiv  <= IDIV_W'((32'(i_win.mn) * 32'(DISP_I_MUL)) >> DISP_I_SHIFT);
            // The display value always fits its 9 bits: the largest window sum gives 499.
            r_scl.vdisp <= VT_W'((32'(i_win.sum) * 32'(DISP_V_MUL)) >> DISP_V_SHIFT);
        end
    end

    assign o_scl_valid = r_valid;
    assign o_scl       = r_scl;

endmodule

// ===== src/scfr_regulate.sv =====
// Regulation stage: configuration registers, firing timer state, step
// decision, clamp and the result register. Depends on scfr_pkg.
`include "scr_charger_firing_regulator_unit_assert.svh"

module scfr_regulate import scfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_scl_valid,
    input  t_scaled           i_scl,
    output logic              o_scl_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TMR_W-1:0]  o_firing_timer,
    output logic [VT_W-1:0]   o_voltage_tenths,
    output logic [CT_W-1:0]   o_current_tenths
);

    localparam logic signed [IDIF_W-1:0] I_LIM_POS = IDIF_W'(I_DIFF_LIM);
    localparam logic signed [IDIF_W-1:0] I_LIM_NEG = -IDIF_W'(I_DIFF_LIM);
    localparam logic signed [5:0] STEP_I_BIG   = -6'sd10;
    localparam logic signed [5:0] STEP_I_SMALL = -6'sd1;

    logic [CFG_W-1:0] r_vsp;
    logic [CFG_W-1:0] r_csp;
    logic             r_en;

    logic [SPS_W-1:0] r_sp;
    logic [SPS_W-1:0] r_lo;
    logic [SPS_W-1:0] r_hi;
    logic [CUR_W-1:0] r_below;
    logic [CUR_W-1:0] r_above;
    logic [CSS_W-1:0] r_cs_scaled;

    logic             r_o_valid;
    logic [TMR_W-1:0] r_firing;
    logic [VT_W-1:0]  r_o_vt;
    logic [CT_W-1:0]  r_o_ct;

    logic                    w_take;
    logic [SPS_W-1:0]        w_vl;
    logic signed [SPS_W:0]   w_vdif;
    logic [SPS_W-1:0]        w_vabs;
    logic                    w_vout;
    logic [4:0]              w_vstep;
    logic                    w_ibelow;
    logic                    w_iabove;
    logic signed [IDIF_W-1:0] w_idif;
    logic                    w_iover;
    logic signed [5:0]       w_delta;
    logic [TMR_W-1:0]        w_stepped;
    logic [TMR_W-1:0]        n_firing;
    logic [31:0]             w_ct_prod;

    // Configuration port. Writes to an unused index are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsp <= '0;
            r_csp <= '0;
            r_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLTAGE_SETPOINT: r_vsp <= i_cfg_data;
                CFG_CURRENT_SETPOINT: r_csp <= i_cfg_data;
                CFG_REGULATE_ENABLE:  r_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Setpoint thresholds are registered products of the setpoints, refreshed every cycle.
    always_ff @(posedge i_clk) begin
        r_sp        <= SPS_W'(r_vsp) * SPS_W'(SP_SCALE);
        r_lo        <= SPS_W'(r_vsp) * SPS_W'(SP_SCALE) + SPS_W'(LO_OFS);
        r_hi        <= SPS_W'(r_vsp) * SPS_W'(SP_SCALE) + SPS_W'(HI_OFS);
        r_below     <= CUR_W'(r_csp) * CUR_W'(I_BELOW);
        r_above     <= CUR_W'(r_csp) * CUR_W'(I_ABOVE);
        r_cs_scaled <= CSS_W'(r_csp) * CSS_W'(IS_SCALE);
    end

    assign w_vl   = SPS_W'(i_scl.vl);
    assign w_vdif = $signed({1'b0, w_vl}) - $signed({1'b0, r_sp});
    assign w_vabs = w_vdif[SPS_W] ? SPS_W'(-w_vdif) : SPS_W'(w_vdif);
    assign w_vout = (w_vl < r_lo) || (w_vl > r_hi);

    always_comb begin
        if (w_vabs > SPS_W'(5 * V_UNIT)) begin
            w_vstep = 5'd25;
        end else if (w_vabs > SPS_W'(4 * V_UNIT)) begin
            w_vstep = 5'd20;
        end else if (w_vabs > SPS_W'(3 * V_UNIT)) begin
            w_vstep = 5'd15;
        end else if (w_vabs > SPS_W'(2 * V_UNIT)) begin
            w_vstep = 5'd10;
        end else if (w_vabs > SPS_W'(V_UNIT)) begin
            w_vstep = 5'd5;
        end else begin
            w_vstep = 5'd1;
        end
    end

    assign w_ibelow = CUR_W'(i_scl.il) < r_below;
    assign w_iabove = CUR_W'(i_scl.il) > r_above;
    assign w_idif   = $signed({3'b0, i_scl.im}) - $signed({1'b0, r_cs_scaled});
    assign w_iover  = (w_idif > I_LIM_POS) || (w_idif < I_LIM_NEG);

    // Voltage control runs only well under the current limit; above the
    // limit the timer backs off, and in between it is held.
    always_comb begin
        w_delta = '0;
        if (r_en) begin
            if (w_ibelow) begin
                if (w_vout) begin
                    w_delta = w_vdif[SPS_W] ? $signed({1'b0, w_vstep})
                                            : -$signed({1'b0, w_vstep});
                end
            end else if (w_iabove) begin
                w_delta = w_iover ? STEP_I_BIG : STEP_I_SMALL;
            end
        end
    end

    // The timer value stays within its clamp range, so adding a small
    // signed step cannot wrap the 16 bit sum.
    assign w_stepped = r_firing + TMR_W'(w_delta);

    always_comb begin
        if (w_stepped < TIMER_MIN) begin
            n_firing = TIMER_MIN;
        end else if (w_stepped > TIMER_MAX) begin
            n_firing = TIMER_MAX;
        end else begin
            n_firing = w_stepped;
        end
    end

    assign w_ct_prod = 32'(i_scl.idiv) * 32'(RECIP3);

    assign o_scl_ready = !r_o_valid || i_ready;
    assign w_take      = i_scl_valid && o_scl_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_firing  <= TIMER_RESET;
        end else begin
            if (w_take) begin
                r_o_valid <= 1'b1;
                r_firing  <= n_firing;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_vt <= i_scl.vdisp;
            r_o_ct <= CT_W'(w_ct_prod >> RECIP3_SHIFT);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_firing_timer   = r_firing;
    assign o_voltage_tenths = r_o_vt;
    assign o_current_tenths = r_o_ct;

    `SCFR_ASSERT_ALWAYS(a_firing_range, (r_firing >= TIMER_MIN) && (r_firing <= TIMER_MAX))
    `SCFR_ASSERT_NEXT(a_hold_when_off, w_take && !r_en, r_firing == $past(r_firing))
    `SCFR_ASSERT_IMP(a_no_rise_at_limit, w_take && !w_ibelow, n_firing <= r_firing)

endmodule

// ===== src/scr_charger_firing_regulator_unit.sv =====
// SCR charger firing regulator, top level.
// Instantiates scfr_accum, scfr_scale and scfr_regulate; uses scfr_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one voltage and current ADC
//   sample pair per word. Every 40 words close a window and produce one
//   result word on the output channel (o_valid / i_ready): the clamped
//   firing timer value and the measured voltage and current in tenths.
//   Words that do not close a window produce no output.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   index 0 voltage setpoint, 1 current setpoint, 2 regulation enable.
//   Throughput is one sample word per cycle while o_ready is high. The
//   window's last word loads the window register at the accepting edge;
//   the window then moves on to the scaling products register and then to
//   the regulation/result register, which drives the result word.
//   If the receiver stalls, the pipeline keeps one finished window in each
//   stage; only the closing word of a window is held off, and only when all
//   three stages are full. Ordinary window words keep flowing.
//   Synchronous reset clears the window, sets the timer value to 60067,
//   clears the setpoints and disables regulation.
module scr_charger_firing_regulator_unit import scfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SMP_W-1:0]  i_voltage_sample,
    input  logic [SMP_W-1:0]  i_current_sample,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TMR_W-1:0]  o_firing_timer,
    output logic [VT_W-1:0]   o_voltage_tenths,
    output logic [CT_W-1:0]   o_current_tenths,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic    w_win_valid;
    logic    w_win_ready;
    t_window w_win;
    logic    w_scl_valid;
    logic    w_scl_ready;
    t_scaled w_scl;

    scfr_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_voltage_sample (i_voltage_sample),
        .i_current_sample (i_current_sample),
        .o_win_valid      (w_win_valid),
        .o_win            (w_win),
        .i_win_ready      (w_win_ready)
    );

    scfr_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (w_win_valid),
        .i_win       (w_win),
        .o_win_ready (w_win_ready),
        .o_scl_valid (w_scl_valid),
        .o_scl       (w_scl),
        .i_scl_ready (w_scl_ready)
    );

    scfr_regulate u_regulate (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_scl_valid      (w_scl_valid),
        .i_scl            (w_scl),
        .o_scl_ready      (w_scl_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_firing_timer   (o_firing_timer),
        .o_voltage_tenths (o_voltage_tenths),
        .o_current_tenths (o_current_tenths)
    );

endmodule
